FILE: rtl/core/hfd_pkg.sv
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

    localparam logic [7:0]  CRC_POLY     = 8'h31;   // x^8+x^5+x^4+1, top bit implied
    localparam logic [15:0] STATUS_MASK  = 16'hFFFC;
    localparam logic [14:0] TEMP_SPAN    = 15'd17572;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4685;
    localparam logic [14:0] HUMI_SPAN    = 15'd12500;
    localparam logic [15:0] HUMI_OFFSET  = 16'd600;

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUMI = 1'b1;

    // one received byte with its side flags
    typedef struct packed {
        logic       frame_start;
        logic       measure_kind;
        logic [7:0] rx_byte;
    } hfd_item_t;

    // decoded frame before scaling
    typedef struct packed {
        logic [15:0] raw_code;
        logic        crc_ok;
        logic        kind;
    } hfd_frame_res_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        crc = crc_in ^ data_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/humidity_temp_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes three-byte measurement frames (MSB, LSB, CRC-8) into a checked
// raw code and a scaled temperature or humidity value.
//
// channel   dir  tdata                                    tuser
// s_        in   [7:0] rx_byte                            [0] measure_kind [1] frame_start
// m_        out  [15:0] raw_code [16] crc_ok [31:17] value [0] kind_out
//
// one byte per cycle while no result is stalled: an input register, then CRC
// check and one constant multiply into the result register
// a result leaves after the third byte of a frame, other bytes give none
// synchronous active-low reset clears the byte counter and both valid flags
// a stalled result blocks only bytes that would produce another result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder_top
    import hfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [0] measure_kind, [1] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] raw_code, [16] crc_ok, [31:17] scaled_value
    output logic [0:0]       m_tuser    // [0] kind_out
);

    hfd_item_t      in_item_reg;
    logic           in_valid_reg;
    logic           emit;
    logic           a_fire;
    logic           out_free;
    hfd_frame_res_t frame_res;
    logic signed [14:0] scaled_value;

    logic [15:0]        raw_code_reg;
    logic               crc_ok_reg;
    logic signed [14:0] scaled_reg;
    logic               kind_reg;
    logic               out_valid_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign a_fire   = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || a_fire;

    hfd_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (in_item_reg),
        .item_fire (a_fire),
        .emit      (emit),
        .res       (frame_res)
    );

    hfd_scale u_scale (
        .raw_code     (frame_res.raw_code),
        .kind         (frame_res.kind),
        .scaled_value (scaled_value)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.rx_byte      <= s_tdata;
            in_item_reg.measure_kind <= s_tuser[0];
            in_item_reg.frame_start  <= s_tuser[1];
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (a_fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire && emit) begin
            raw_code_reg <= frame_res.raw_code;
            crc_ok_reg   <= frame_res.crc_ok;
            scaled_reg   <= scaled_value;
            kind_reg     <= frame_res.kind;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {scaled_reg, crc_ok_reg, raw_code_reg};
    assign m_tuser[0] = kind_reg;

`ifndef SYNTH
    // a failed checksum always carries a zeroed code
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !crc_ok_reg |-> raw_code_reg == 16'h0000)
        else $error("nonzero code on failed checksum");

    // a failed checksum scales from code zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !crc_ok_reg |->
            (scaled_reg == -15'sd4685 || scaled_reg == -15'sd600))
        else $error("bad scaled value on failed checksum");

    // a held byte is neither lost nor altered
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !a_fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("held input byte changed");

    // an emitted result lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_fire && emit |=> out_valid_reg)
        else $error("emitted result missing");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/hfd_frame.sv
// ----------------------------------------------------------------------------
// hfd_frame
// Byte position tracking, data byte capture and running CRC-8 of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfd_frame
    import hfd_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire hfd_item_t      item,
    input  wire logic           item_fire,
    output logic                emit,
    output hfd_frame_res_t      res
);

    localparam logic [1:0] IDX_HIGH = 2'd0;
    localparam logic [1:0] IDX_LOW  = 2'd1;
    localparam logic [1:0] IDX_CRC  = 2'd2;

    logic [1:0] byte_index_reg, byte_index_next;
    logic [7:0] high_byte_reg, high_byte_next;
    logic [7:0] low_byte_reg, low_byte_next;
    logic [7:0] crc_reg, crc_next;
    logic       kind_reg, kind_next;
    logic [1:0] idx;
    logic       ok;

    assign idx = item.frame_start ? IDX_HIGH : byte_index_reg;
    assign ok  = (crc_reg == item.rx_byte);

    always_comb begin
        byte_index_next = byte_index_reg;
        high_byte_next  = high_byte_reg;
        low_byte_next   = low_byte_reg;
        crc_next        = crc_reg;
        kind_next       = kind_reg;
        emit            = 1'b0;
        unique case (idx)
            IDX_LOW: begin
                low_byte_next   = item.rx_byte;
                crc_next        = crc8_byte(crc_reg, item.rx_byte);
                byte_index_next = IDX_CRC;
            end
            IDX_CRC: begin
                emit            = 1'b1;
                byte_index_next = IDX_HIGH;
            end
            default: begin
                // first byte; an index of three is treated the same way
                high_byte_next  = item.rx_byte;
                kind_next       = item.measure_kind;
                crc_next        = crc8_byte(8'h00, item.rx_byte);
                byte_index_next = IDX_LOW;
            end
        endcase
    end

    assign res.raw_code = ok ? {high_byte_reg, low_byte_reg} : 16'h0000;
    assign res.crc_ok   = ok;
    assign res.kind     = kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= IDX_HIGH;
        end else if (item_fire) begin
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            high_byte_reg <= high_byte_next;
            low_byte_reg  <= low_byte_next;
            crc_reg       <= crc_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hfd_scale.sv
// ----------------------------------------------------------------------------
// hfd_scale
// Converts a 16-bit code to hundredths of degC or %RH by one constant multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfd_scale
    import hfd_pkg::*;
(
    input  wire logic [15:0]        raw_code,
    input  wire logic               kind,
    output logic signed [14:0]      scaled_value
);

    logic [15:0] code_masked;
    logic [14:0] span;
    logic [15:0] offset;
    logic [30:0] product;
    logic [15:0] diff;

    assign code_masked = raw_code & STATUS_MASK;
    assign span        = (kind == KIND_HUMI) ? HUMI_SPAN : TEMP_SPAN;
    assign offset      = (kind == KIND_HUMI) ? HUMI_OFFSET : TEMP_OFFSET;
    assign product     = 31'(span) * 31'(code_masked);
    // upper bits of the product are the floor of span*code/65536
    assign diff         = {1'b0, product[30:16]} - offset;
    assign scaled_value = signed'(diff[14:0]);

endmodule

`default_nettype wire
